[hw/rtl/msdc_pkg.sv]
// Shared types, constants and helper functions of the step/dir controller.
package msdc_pkg;

  // Sizes fixed by the item and result fields
  localparam int NUM_AXES_DEF = 5;
  localparam int PIN_W        = 5;
  localparam int AXIS_W       = 3;
  localparam int OP_W         = 3;
  localparam int ST_W         = 4;
  localparam int POS_W        = 32;
  localparam int HP_W         = 16;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 48;

  // Output queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [HP_W-1:0] HOME_HP_RST = 16'd800;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_HOME    = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd4;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd5;
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD    = 3'd7;

  // Status codes
  localparam logic [ST_W-1:0] ST_NONE        = 4'd0;
  localparam logic [ST_W-1:0] ST_MOVE_DONE   = 4'd1;
  localparam logic [ST_W-1:0] ST_AXIS_HOMED  = 4'd2;
  localparam logic [ST_W-1:0] ST_ALL_HOMED   = 4'd3;
  localparam logic [ST_W-1:0] ST_BAD_AXIS    = 4'd4;
  localparam logic [ST_W-1:0] ST_DISABLED    = 4'd5;
  localparam logic [ST_W-1:0] ST_STOPPED     = 4'd6;
  localparam logic [ST_W-1:0] ST_ENABLED     = 4'd7;
  localparam logic [ST_W-1:0] ST_DISABLE_ACK = 4'd8;
  localparam logic [ST_W-1:0] ST_BUSY        = 4'd9;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2
  } run_mode_t;

  // Position update requested of the position unit
  typedef enum logic [1:0] {
    PK_NONE,
    PK_ZERO,
    PK_INC,
    PK_DEC
  } pos_kind_t;

  // Control stage to position stage
  typedef struct packed {
    pos_kind_t         kind;
    logic [AXIS_W-1:0] axis;
    logic              pos_zero;
    logic [PIN_W-1:0]  step_pins;
    logic [PIN_W-1:0]  dir_pins;
    logic              enable_pin_n;
    logic              busy_res;
    logic              estop_active;
    logic [ST_W-1:0]   status;
  } pos_req_t;

  // One finished result
  typedef struct packed {
    logic [PIN_W-1:0]        step_pins;
    logic [PIN_W-1:0]        dir_pins;
    logic                    enable_pin_n;
    logic                    busy_res;
    logic                    estop_active;
    logic [ST_W-1:0]         status;
    logic [AXIS_W-1:0]       axis_out;
    logic signed [POS_W-1:0] position;
  } result_t;

  // Limit input reads as hit (0) for the axis; axes beyond the pins read as hit
  function automatic logic lim_hit(input logic [PIN_W-1:0] v, input logic [AXIS_W-1:0] a);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < PIN_W; i++) begin
      if (a == i[AXIS_W-1:0]) hit = ~v[i];
    end
    return hit;
  endfunction

  // One-hot pin mask of an axis
  function automatic logic [PIN_W-1:0] axis_mask(input logic [AXIS_W-1:0] a);
    logic [PIN_W-1:0] m;
    for (int i = 0; i < PIN_W; i++) begin
      m[i] = (a == i[AXIS_W-1:0]);
    end
    return m;
  endfunction

endpackage

[hw/rtl/msdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module msdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  // Registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem_r[rd_addr];
  end

endmodule

[hw/rtl/msdc_ctrl.sv]
// Command decode, run sequencer and pulse timing; issues the position read.
module msdc_ctrl #(
  parameter int NUM_AXES = msdc_pkg::NUM_AXES_DEF,
  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_accept,
  input  logic [msdc_pkg::OP_W-1:0]           in_operation,
  input  logic [msdc_pkg::AXIS_W-1:0]         in_axis,
  input  logic [msdc_pkg::POS_W-1:0]          in_step_count,
  input  logic [msdc_pkg::HP_W-1:0]           in_half_period_us,
  input  logic                                in_estop_in,
  input  logic [msdc_pkg::PIN_W-1:0]          in_limit_min_in,
  input  logic [msdc_pkg::PIN_W-1:0]          in_limit_max_in,
  input  logic                                cfg_wr_en,
  input  logic [msdc_pkg::HP_W-1:0]           cfg_wr_data,
  output logic                                req_valid,
  output msdc_pkg::pos_req_t                  req,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr
);

  localparam logic [3:0] NAX = 4'(NUM_AXES);

  msdc_pkg::run_mode_t               mode_r, mode_nxt;
  logic                              drives_r, drives_nxt;
  logic                              latch_r, latch_nxt;
  logic [msdc_pkg::AXIS_W-1:0]       act_axis_r, act_axis_nxt;
  logic [msdc_pkg::POS_W-1:0]        steps_left_r, steps_left_nxt;
  logic                              move_pos_r, move_pos_nxt;
  logic [msdc_pkg::HP_W-1:0]         phase_r, phase_nxt;
  logic                              pulse_hi_r, pulse_hi_nxt;
  logic [msdc_pkg::HP_W-1:0]         act_hp_r, act_hp_nxt;
  logic [msdc_pkg::HP_W-1:0]         home_hp_r;
  logic                              req_valid_r;
  msdc_pkg::pos_req_t                req_r, req_nxt;

  logic                              busy;
  logic                              emerg;
  logic                              halt;
  logic                              stop_run;
  logic                              level;
  logic                              ph_hi;
  logic [msdc_pkg::HP_W-1:0]         ph;
  logic [msdc_pkg::POS_W-1:0]        steps_dec;
  logic [msdc_pkg::POS_W-1:0]        steps_abs;
  logic [msdc_pkg::ST_W-1:0]         status;
  logic [msdc_pkg::AXIS_W-1:0]       rep;
  logic [msdc_pkg::AXIS_W-1:0]       a;
  msdc_pkg::pos_kind_t               kind;

  assign busy      = (mode_r != msdc_pkg::MODE_IDLE);
  assign emerg     = latch_r | ~in_estop_in;
  assign a         = act_axis_r;
  assign steps_dec = steps_left_r - 32'd1;
  assign steps_abs = in_step_count[msdc_pkg::POS_W-1] ? (32'd0 - in_step_count) : in_step_count;

  // Next state and result fields of the accepted transaction
  always_comb begin
    mode_nxt       = mode_r;
    drives_nxt     = drives_r;
    latch_nxt      = latch_r;
    act_axis_nxt   = act_axis_r;
    steps_left_nxt = steps_left_r;
    move_pos_nxt   = move_pos_r;
    phase_nxt      = phase_r;
    pulse_hi_nxt   = pulse_hi_r;
    act_hp_nxt     = act_hp_r;
    status         = msdc_pkg::ST_NONE;
    rep            = act_axis_r;
    kind           = msdc_pkg::PK_NONE;
    level          = busy & pulse_hi_r;
    halt           = 1'b0;
    stop_run       = 1'b0;
    ph             = phase_r;
    ph_hi          = pulse_hi_r;

    if (in_accept) begin
      if (in_operation == msdc_pkg::OP_TICK) begin
        if (busy) begin
          level = 1'b0;
          // Start of a step: limit and e-stop checks
          if (phase_r == '0) begin
            if (mode_r == msdc_pkg::MODE_HOME) begin
              if (msdc_pkg::lim_hit(in_limit_min_in, a)) begin
                kind     = msdc_pkg::PK_ZERO;
                stop_run = 1'b1;
                if (({1'b0, a} + 4'd1) < NAX) begin
                  act_axis_nxt = a + 3'd1;
                  status       = msdc_pkg::ST_AXIS_HOMED;
                end else begin
                  mode_nxt = msdc_pkg::MODE_IDLE;
                  status   = msdc_pkg::ST_ALL_HOMED;
                end
              end else if (emerg) begin
                halt     = 1'b1;
                stop_run = 1'b1;
                status   = msdc_pkg::ST_STOPPED;
              end
            end else if (emerg || (move_pos_r ? msdc_pkg::lim_hit(in_limit_max_in, a)
                                              : msdc_pkg::lim_hit(in_limit_min_in, a))) begin
              halt     = 1'b1;
              stop_run = 1'b1;
              status   = msdc_pkg::ST_STOPPED;
            end
            if (!stop_run) begin
              ph_hi = 1'b1;
              ph    = act_hp_r;
            end
          end
          // Pulse phase countdown
          if (!stop_run) begin
            level = ph_hi;
            ph    = ph - 16'd1;
            if (ph == '0) begin
              if (ph_hi) begin
                ph_hi = 1'b0;
                ph    = act_hp_r;
              end else if (mode_r == msdc_pkg::MODE_MOVE) begin
                kind           = move_pos_r ? msdc_pkg::PK_INC : msdc_pkg::PK_DEC;
                steps_left_nxt = steps_dec;
                if (steps_dec == '0) begin
                  mode_nxt = msdc_pkg::MODE_IDLE;
                  status   = msdc_pkg::ST_MOVE_DONE;
                end
              end
            end
            phase_nxt    = ph;
            pulse_hi_nxt = ph_hi;
          end
        end else if (!in_estop_in) begin
          halt   = 1'b1;
          status = msdc_pkg::ST_STOPPED;
        end
      end else if (busy && (in_operation != msdc_pkg::OP_RSVD)) begin
        status = msdc_pkg::ST_BUSY;
      end else begin
        unique case (in_operation)
          msdc_pkg::OP_MOVE: begin
            rep = in_axis;
            if (!({1'b0, in_axis} < NAX)) begin
              status = msdc_pkg::ST_BAD_AXIS;
            end else if (!drives_r) begin
              status = msdc_pkg::ST_DISABLED;
            end else if (emerg) begin
              halt   = 1'b1;
              status = msdc_pkg::ST_STOPPED;
            end else begin
              act_axis_nxt   = in_axis;
              move_pos_nxt   = ~in_step_count[msdc_pkg::POS_W-1];
              steps_left_nxt = steps_abs;
              pulse_hi_nxt   = 1'b0;
              phase_nxt      = '0;
              act_hp_nxt     = (in_half_period_us == '0) ? 16'd1 : in_half_period_us;
              if (steps_abs == '0) status = msdc_pkg::ST_MOVE_DONE;
              else mode_nxt = msdc_pkg::MODE_MOVE;
            end
          end
          msdc_pkg::OP_HOME: begin
            latch_nxt      = 1'b0;
            drives_nxt     = 1'b1;
            mode_nxt       = msdc_pkg::MODE_HOME;
            act_axis_nxt   = '0;
            move_pos_nxt   = 1'b0;
            steps_left_nxt = '0;
            pulse_hi_nxt   = 1'b0;
            phase_nxt      = '0;
            act_hp_nxt     = (home_hp_r == '0) ? 16'd1 : home_hp_r;
            rep            = '0;
          end
          msdc_pkg::OP_STOP: begin
            halt   = 1'b1;
            status = msdc_pkg::ST_STOPPED;
          end
          msdc_pkg::OP_ENABLE: begin
            latch_nxt  = 1'b0;
            drives_nxt = 1'b1;
            status     = msdc_pkg::ST_ENABLED;
          end
          msdc_pkg::OP_DISABLE: begin
            drives_nxt = 1'b0;
            status     = msdc_pkg::ST_DISABLE_ACK;
          end
          msdc_pkg::OP_STATUS: begin
            rep = in_axis;
            if (!({1'b0, in_axis} < NAX)) status = msdc_pkg::ST_BAD_AXIS;
          end
          default: ;
        endcase
      end
    end

    // E-stop halt overrides the run state
    if (halt) begin
      latch_nxt    = 1'b1;
      drives_nxt   = 1'b0;
      mode_nxt     = msdc_pkg::MODE_IDLE;
      pulse_hi_nxt = 1'b0;
      phase_nxt    = '0;
    end

    // Result fields, taken after the state update
    req_nxt.kind         = kind;
    req_nxt.axis         = rep;
    req_nxt.pos_zero     = (status == msdc_pkg::ST_BAD_AXIS) || !({1'b0, rep} < NAX);
    req_nxt.step_pins    = level ? msdc_pkg::axis_mask(act_axis_nxt) : '0;
    req_nxt.dir_pins     = move_pos_nxt ? msdc_pkg::axis_mask(act_axis_nxt) : '0;
    req_nxt.enable_pin_n = ~drives_nxt;
    req_nxt.busy_res     = (mode_nxt != msdc_pkg::MODE_IDLE);
    req_nxt.estop_active = latch_nxt | ~in_estop_in;
    req_nxt.status       = status;
  end

  // Run state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= msdc_pkg::MODE_IDLE;
      drives_r     <= 1'b0;
      latch_r      <= 1'b0;
      act_axis_r   <= '0;
      steps_left_r <= '0;
      move_pos_r   <= 1'b0;
      phase_r      <= '0;
      pulse_hi_r   <= 1'b0;
      act_hp_r     <= '0;
      home_hp_r    <= msdc_pkg::HOME_HP_RST;
      req_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      drives_r     <= drives_nxt;
      latch_r      <= latch_nxt;
      act_axis_r   <= act_axis_nxt;
      steps_left_r <= steps_left_nxt;
      move_pos_r   <= move_pos_nxt;
      phase_r      <= phase_nxt;
      pulse_hi_r   <= pulse_hi_nxt;
      act_hp_r     <= act_hp_nxt;
      req_valid_r  <= in_accept;
      if (cfg_wr_en) home_hp_r <= cfg_wr_data;
    end
  end

  // Request payload to the position stage
  always_ff @(posedge clk) begin
    if (in_accept) req_r <= req_nxt;
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;
  assign rd_en     = in_accept;
  assign rd_addr   = rep[AW-1:0];

endmodule

[hw/rtl/msdc_pos.sv]
// Position read-modify-write stage with write forwarding and reset-valid bits.
module msdc_pos #(
  parameter int NUM_AXES = msdc_pkg::NUM_AXES_DEF,
  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  msdc_pkg::pos_req_t            req,
  input  logic [msdc_pkg::POS_W-1:0]    rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [msdc_pkg::POS_W-1:0]    wr_data,
  output logic                          res_valid,
  output msdc_pkg::result_t             res
);

  logic [NUM_AXES-1:0]          vld_r;
  logic                         lw_valid_r;
  logic [AW-1:0]                lw_addr_r;
  logic [msdc_pkg::POS_W-1:0]   lw_data_r;

  logic [AW-1:0]                addr;
  logic                         vld_sel;
  logic [msdc_pkg::POS_W-1:0]   cur;
  logic [msdc_pkg::POS_W-1:0]   upd;

  assign addr = req.axis[AW-1:0];

  // Entry written since reset?
  always_comb begin
    vld_sel = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (addr == i[AW-1:0]) vld_sel = vld_r[i];
    end
  end

  // Current value: forward the write made on the read edge
  always_comb begin
    if (lw_valid_r && (lw_addr_r == addr)) cur = lw_data_r;
    else if (vld_sel)                      cur = rd_data;
    else                                   cur = '0;
  end

  // Modify
  always_comb begin
    case (req.kind)
      msdc_pkg::PK_ZERO: upd = '0;
      msdc_pkg::PK_INC:  upd = cur + 32'd1;
      msdc_pkg::PK_DEC:  upd = cur - 32'd1;
      default:           upd = cur;
    endcase
  end

  assign wr_en   = req_valid && (req.kind != msdc_pkg::PK_NONE);
  assign wr_addr = addr;
  assign wr_data = upd;

  // Valid bits and last-write forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      lw_valid_r <= 1'b0;
    end else begin
      lw_valid_r <= wr_en;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (wr_en && (addr == i[AW-1:0])) vld_r[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= addr;
      lw_data_r <= upd;
    end
  end

  // Finished result
  assign res_valid        = req_valid;
  assign res.step_pins    = req.step_pins;
  assign res.dir_pins     = req.dir_pins;
  assign res.enable_pin_n = req.enable_pin_n;
  assign res.busy_res     = req.busy_res;
  assign res.estop_active = req.estop_active;
  assign res.status       = req.status;
  assign res.axis_out     = req.axis;
  assign res.position     = req.pos_zero ? '0 : $signed(upd);

endmodule

[hw/rtl/msdc_outq.sv]
// Small output queue that decouples result delivery from the pipeline.
module msdc_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  msdc_pkg::result_t              push_data,
  input  logic                           pop_ready,
  output logic                           head_valid,
  output msdc_pkg::result_t              head_data,
  output logic [msdc_pkg::OUTQ_CW-1:0]   cnt
);

  localparam logic [msdc_pkg::OUTQ_PW-1:0] LAST = msdc_pkg::OUTQ_PW'(msdc_pkg::OUTQ_DEPTH - 1);

  msdc_pkg::result_t                 mem_r [msdc_pkg::OUTQ_DEPTH];
  logic [msdc_pkg::OUTQ_PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [msdc_pkg::OUTQ_CW-1:0]      cnt_r;
  logic                              pop;

  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign cnt        = cnt_r;
  assign pop        = head_valid & pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[hw/rtl/multi_axis_step_dir_controller.sv]
// Top level of the five-axis step/direction pulse generator.
//
// Usage:
//   in_*  : one transaction per tick or command. in_tuser is the operation
//           (tick, move, home all, stop, enable, disable, status read);
//           in_tdata carries axis, step count, half period and the sampled
//           e-stop and limit inputs. Send one tick per microsecond.
//   out_* : exactly one result per input transaction, in order: pin levels,
//           drive enable, busy, e-stop, status code (in out_tuser), axis and
//           its signed position.
//   cfg_* : writes the homing half period; write only while idle.
// Path: an accepted input is registered, then its result enters the output queue.
// Throughput: one transaction per cycle while in_tready is high. Axis positions
//   live in a small RAM; each transaction reads one entry and writes it back in
//   the next cycle, with the previous write forwarded, so consecutive steps never wait.
// Reset: positions read as zero, drives disabled, e-stop clear, idle,
//   homing half period 800. No clearing pass is needed.
// Stall: results wait in a three-entry queue; in_tready drops once the
//   queue plus the transaction in flight fill it, and nothing is lost.
module multi_axis_step_dir_controller #(
  parameter int NUM_AXES = msdc_pkg::NUM_AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: axis[2:0], step_count[34:3], half_period_us[50:35], estop_in[51],
  //        limit_min_in[56:52], limit_max_in[61:57], zero fill[63:62]
  input  logic [msdc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: operation[2:0]
  input  logic [msdc_pkg::OP_W-1:0]            in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: step_pins[4:0], dir_pins[9:5], enable_pin_n[10], busy_res[11],
  //        estop_active[12], axis_out[15:13], position[47:16]
  output logic [msdc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tuser: status[3:0]
  output logic [msdc_pkg::ST_W-1:0]            out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [msdc_pkg::HP_W-1:0]            cfg_wr_data
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic                              in_accept;
  logic                              req_valid;
  msdc_pkg::pos_req_t                req;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [msdc_pkg::POS_W-1:0]        rd_data;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [msdc_pkg::POS_W-1:0]        wr_data;
  logic                              res_valid;
  msdc_pkg::result_t                 res;
  msdc_pkg::result_t                 head;
  logic [msdc_pkg::OUTQ_CW-1:0]      q_cnt;

  // Accept while the queue has room for everything in flight
  assign in_tready = (({1'b0, q_cnt} + {{msdc_pkg::OUTQ_CW{1'b0}}, req_valid})
                      < (msdc_pkg::OUTQ_CW + 1)'(msdc_pkg::OUTQ_DEPTH));
  assign in_accept = in_tvalid & in_tready;

  msdc_ctrl #(.NUM_AXES(NUM_AXES)) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_operation      (in_tuser),
    .in_axis           (in_tdata[2:0]),
    .in_step_count     (in_tdata[34:3]),
    .in_half_period_us (in_tdata[50:35]),
    .in_estop_in       (in_tdata[51]),
    .in_limit_min_in   (in_tdata[56:52]),
    .in_limit_max_in   (in_tdata[61:57]),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_valid         (req_valid),
    .req               (req),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr)
  );

  msdc_ram #(.WIDTH(msdc_pkg::POS_W), .DEPTH(NUM_AXES)) u_pos_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  msdc_pos #(.NUM_AXES(NUM_AXES)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res)
  );

  msdc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head_data  (head),
    .cnt        (q_cnt)
  );

  // Result packing
  assign out_tdata = {head.position, head.axis_out, head.estop_active, head.busy_res,
                      head.enable_pin_n, head.dir_pins, head.step_pins};
  assign out_tuser = head.status;

endmodule

[hw/rtl/msdc_checker.sv]
// Port-level checks of the step/dir controller, bound to the top level.
module msdc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic [msdc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [msdc_pkg::ST_W-1:0]          out_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only the active axis can pulse or show direction
  a_pins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[4:0]) && $onehot0(out_tdata[9:5]))
    else $error("more than one axis pin active");

  // A bad axis reports position zero
  a_bad_axis_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == msdc_pkg::ST_BAD_AXIS) |-> (out_tdata[47:16] == '0))
    else $error("bad axis with nonzero position");

  // A rejected command is only reported while a run is in progress
  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == msdc_pkg::ST_BUSY) |-> out_tdata[11])
    else $error("busy status while idle");

  // A stop leaves e-stop active, drives disabled and the run idle
  a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == msdc_pkg::ST_STOPPED)
      |-> out_tdata[12] && out_tdata[10] && !out_tdata[11] && (out_tdata[4:0] == '0))
    else $error("stop status with drives still enabled");

endmodule

bind multi_axis_step_dir_controller msdc_checker u_msdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[test/tb_top.sv]
// Self-checking testbench of the five-axis step/direction controller.
`timescale 1ns / 1ps

module tb_top;
  import msdc_pkg::*;

  localparam int AXES = NUM_AXES_DEF;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [OP_W-1:0]        in_tuser    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [HP_W-1:0]        cfg_wr_data = '0;

  multi_axis_step_dir_controller DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted controller state
  logic [31:0]     pos_tab [AXES];
  logic            drv_on;
  logic            estop_held;
  run_mode_t       mode;
  logic [2:0]      cur_axis;
  logic [31:0]     steps_rem;
  logic            dir_pos;
  logic [15:0]     timer;
  logic            pulse_on;
  logic [15:0]     half_per;
  logic [15:0]     home_hp;

  result_t pending_results [$];
  int      mismatch_cnt = 0;
  int      result_idx   = 0;
  int      items_sent   = 0;
  int      burst_left   = 0;
  bit      no_gaps      = 1'b0;
  bit      hold_req     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic logic limit_is_hit(input logic [4:0] v, input logic [2:0] a);
    return (a >= AXES) ? 1'b1 : ~v[a];
  endfunction

  function automatic void halt_drives();
    estop_held = 1'b1;
    drv_on     = 1'b0;
    mode       = MODE_IDLE;
    pulse_on   = 1'b0;
    timer      = '0;
  endfunction

  // One tick of a running move or homing run; returns the status code
  function automatic logic [3:0] advance_run(input logic emerg, input logic [4:0] lmin,
                                             input logic [4:0] lmax,
                                             output logic [2:0] rep, output logic level);
    logic [2:0] a;
    logic       hit;
    a     = cur_axis;
    level = 1'b0;
    rep   = a;
    // step start: limit and emergency checks
    if (timer == 0) begin
      if (mode == MODE_HOME) begin
        if (limit_is_hit(lmin, a)) begin
          if (a < AXES) pos_tab[a] = '0;
          if (a + 1 < AXES) begin
            cur_axis = a + 3'd1;
            return ST_AXIS_HOMED;
          end
          mode = MODE_IDLE;
          return ST_ALL_HOMED;
        end
        if (emerg) begin
          halt_drives();
          return ST_STOPPED;
        end
      end else begin
        hit = dir_pos ? limit_is_hit(lmax, a) : limit_is_hit(lmin, a);
        if (emerg || hit) begin
          halt_drives();
          return ST_STOPPED;
        end
      end
      pulse_on = 1'b1;
      timer    = half_per;
    end
    level = pulse_on;
    timer = timer - 16'd1;
    // end of a half period
    if (timer == 0) begin
      if (pulse_on) begin
        pulse_on = 1'b0;
        timer    = half_per;
      end else if (mode == MODE_MOVE) begin
        if (a < AXES) pos_tab[a] = pos_tab[a] + (dir_pos ? 32'd1 : 32'hFFFF_FFFF);
        steps_rem = steps_rem - 32'd1;
        if (steps_rem == 0) begin
          mode = MODE_IDLE;
          return ST_MOVE_DONE;
        end
      end
    end
    return ST_NONE;
  endfunction

  function automatic result_t controller_step(input logic [2:0] op, input logic [2:0] ax,
                                              input logic [31:0] cnt, input logic [15:0] hp,
                                              input logic est_ok, input logic [4:0] lmin,
                                              input logic [4:0] lmax);
    result_t    r;
    logic [3:0] st;
    logic [2:0] rep;
    logic       level;
    logic       busy;
    logic [4:0] pin_bit;
    st    = ST_NONE;
    rep   = cur_axis;
    busy  = (mode != MODE_IDLE);
    level = busy && pulse_on;
    if (op == OP_TICK) begin
      if (busy) st = advance_run(estop_held || !est_ok, lmin, lmax, rep, level);
      else if (!est_ok) begin
        halt_drives();
        st = ST_STOPPED;
      end
    end else if (op != OP_RSVD && busy) begin
      st = ST_BUSY;
    end else begin
      case (op)
        OP_MOVE: begin
          rep = ax;
          if (ax >= AXES) st = ST_BAD_AXIS;
          else if (!drv_on) st = ST_DISABLED;
          else if (estop_held || !est_ok) begin
            halt_drives();
            st = ST_STOPPED;
          end else begin
            cur_axis  = ax;
            dir_pos   = ~cnt[31];
            steps_rem = cnt[31] ? (32'd0 - cnt) : cnt;
            pulse_on  = 1'b0;
            timer     = '0;
            half_per  = (hp == 0) ? 16'd1 : hp;
            if (steps_rem == 0) st = ST_MOVE_DONE;
            else mode = MODE_MOVE;
          end
        end
        OP_HOME: begin
          estop_held = 1'b0;
          drv_on     = 1'b1;
          mode       = MODE_HOME;
          cur_axis   = '0;
          dir_pos    = 1'b0;
          steps_rem  = '0;
          pulse_on   = 1'b0;
          timer      = '0;
          half_per   = (home_hp == 0) ? 16'd1 : home_hp;
          rep        = '0;
        end
        OP_STOP: begin
          halt_drives();
          st = ST_STOPPED;
        end
        OP_ENABLE: begin
          estop_held = 1'b0;
          drv_on     = 1'b1;
          st         = ST_ENABLED;
        end
        OP_DISABLE: begin
          drv_on = 1'b0;
          st     = ST_DISABLE_ACK;
        end
        OP_STATUS: begin
          rep = ax;
          if (ax >= AXES) st = ST_BAD_AXIS;
        end
        default: ;
      endcase
    end
    pin_bit        = 5'b00001 << cur_axis;
    r.step_pins    = level ? pin_bit : 5'b0;
    r.dir_pins     = dir_pos ? pin_bit : 5'b0;
    r.enable_pin_n = ~drv_on;
    r.busy_res     = (mode != MODE_IDLE);
    r.estop_active = estop_held || !est_ok;
    r.status       = st;
    r.axis_out     = rep;
    r.position     = (st == ST_BAD_AXIS || rep >= AXES) ? 32'd0 : pos_tab[rep];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d: %s expected %h, got %h", result_idx, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result %0d arrived with nothing expected: tdata %h tuser %h",
                   result_idx, out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("step_pins", want.step_pins, out_tdata[4:0]);
        check_field("dir_pins", want.dir_pins, out_tdata[9:5]);
        check_field("enable_pin_n", want.enable_pin_n, out_tdata[10]);
        check_field("busy_res", want.busy_res, out_tdata[11]);
        check_field("estop_active", want.estop_active, out_tdata[12]);
        check_field("axis_out", want.axis_out, out_tdata[15:13]);
        check_field("position", want.position, out_tdata[47:16]);
        check_field("status", want.status, out_tuser);
      end
      result_idx++;
    end
  end

  // Receiver: changing stall pattern, plus a long hold-off on request
  initial begin : result_sink
    int  pat_left;
    int  pat;
    int  stall_left;
    int  phase;
    bit  hold_seen;
    pat_left   = 0;
    pat        = 0;
    stall_left = 0;
    phase      = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) stall_left = 60;
      hold_seen = hold_req;
      if (pat_left == 0) begin
        pat      = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      phase++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        case (pat)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 4) != 0);
          default: out_tready <= (phase % 4 != 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  // One input transaction, sent in bursts with random gaps
  task automatic send_item(input logic [2:0] op, input logic [2:0] ax, input logic [31:0] cnt,
                           input logic [15:0] hp, input logic est_ok, input logic [4:0] lmin,
                           input logic [4:0] lmax);
    int gap;
    if (!no_gaps && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_tuser  <= op;
    in_tdata  <= {2'b00, lmax, lmin, est_ok, hp, cnt, ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(controller_step(op, ax, cnt, hp, est_ok, lmin, lmax));
    items_sent++;
  endtask

  // Tick with don't-care command fields randomized
  task automatic send_tick(input logic est_ok, input logic [4:0] lmin, input logic [4:0] lmax);
    send_item(OP_TICK, 3'($urandom), $urandom, 16'($urandom), est_ok, lmin, lmax);
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [2:0] ax, input logic [31:0] cnt,
                          input logic [15:0] hp);
    send_item(op, ax, cnt, hp, 1'b1, 5'($urandom), 5'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Homing half period write, only with the block idle
  task automatic write_home_period(input logic [15:0] v);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    home_hp = v;
    repeat (2) @(posedge clk);
  endtask

  // Tick a run along with mostly clean inputs, then force it down by e-stop
  task automatic settle_run(input int cap, input bit homing);
    int         n;
    logic [4:0] lmin;
    logic [4:0] lmax;
    n = 0;
    while (mode != MODE_IDLE && n < cap) begin
      if ($urandom_range(0, 14) == 0) begin
        // command during a run gets rejected
        send_cmd(3'($urandom_range(1, 6)), 3'($urandom), $urandom, 16'($urandom));
      end else begin
        if (homing) lmin = ~(5'($urandom) & 5'($urandom));
        else lmin = ($urandom_range(0, 39) == 0) ? 5'($urandom) : 5'h1F;
        lmax = ($urandom_range(0, 39) == 0) ? 5'($urandom) : 5'h1F;
        send_tick($urandom_range(0, 59) != 0, lmin, lmax);
      end
      n++;
    end
    while (mode != MODE_IDLE) send_tick(1'b0, 5'h1F, 5'h1F);
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_idle_commands();
    send_cmd(OP_STATUS, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_STATUS, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_RSVD, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 5'h1F, 5'h1F);
    // bad axis wins over disabled drives
    send_cmd(OP_MOVE, 3'd5, 32'd10, 16'd1);
    send_cmd(OP_MOVE, 3'd4, 32'h8000_0000, 16'hFFFF);
    send_tick(1'b0, 5'h00, 5'h00);
    send_cmd(OP_STOP, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_ENABLE, 3'd0, 32'd0, 16'd0);
    send_tick(1'b1, 5'h00, 5'h00);
  endtask

  task automatic test_moves();
    send_cmd(OP_MOVE, 3'd2, 32'd0, 16'd5);
    // one negative step with zero half period
    send_cmd(OP_MOVE, 3'd0, 32'hFFFF_FFFF, 16'd0);
    repeat (2) send_tick(1'b1, 5'h1F, 5'h1F);
    // commands during a move are rejected
    send_cmd(OP_MOVE, 3'd1, 32'd3, 16'd1);
    send_cmd(OP_STOP, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_STATUS, 3'd1, 32'd0, 16'd0);
    repeat (6) send_tick(1'b1, 5'h1F, 5'h1F);
    // e-stop mid step is ignored, max limit at next step start aborts
    send_cmd(OP_MOVE, 3'd4, 32'h7FFF_FFFF, 16'd2);
    repeat (2) send_tick(1'b1, 5'h1F, 5'h1F);
    send_tick(1'b0, 5'h1F, 5'h1F);
    send_tick(1'b1, 5'h1F, 5'h1F);
    send_tick(1'b1, 5'h1F, 5'h0F);
    // emergency at a step start while running
    send_cmd(OP_ENABLE, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_MOVE, 3'd3, 32'h8000_0000, 16'd1);
    repeat (2) send_tick(1'b1, 5'h1F, 5'h1F);
    send_tick(1'b0, 5'h1F, 5'h1F);
    // min limit blocks a negative move
    send_cmd(OP_ENABLE, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_MOVE, 3'd1, 32'hFFFF_FFFE, 16'd1);
    send_tick(1'b1, 5'h1D, 5'h1F);
    send_cmd(OP_ENABLE, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_DISABLE, 3'd0, 32'd0, 16'd0);
    send_cmd(OP_MOVE, 3'd1, 32'd5, 16'd1);
  endtask

  task automatic test_homing();
    // longest half period: every axis already at its min limit
    write_home_period(16'hFFFF);
    send_cmd(OP_HOME, 3'd0, 32'd0, 16'd0);
    repeat (5) send_tick(1'b1, 5'h00, 5'h1F);
    // shortest half period with random limit release
    write_home_period(16'd1);
    send_cmd(OP_MOVE, 3'd2, 32'd2, 16'd1);
    settle_run(20, 1'b0);
    send_cmd(OP_HOME, 3'd0, 32'd0, 16'd0);
    settle_run(300, 1'b1);
    send_cmd(OP_STATUS, 3'd2, 32'd0, 16'd0);
    // emergency aborts the whole homing run
    send_cmd(OP_HOME, 3'd0, 32'd0, 16'd0);
    send_tick(1'b0, 5'h1F, 5'h1F);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    no_gaps  = 1'b1;
    hold_req <= 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1)) send_cmd(OP_STATUS, 3'($urandom), $urandom, 16'($urandom));
      else send_tick(1'b1, 5'h1F, 5'h1F);
    end
    hold_req <= 1'b0;
    no_gaps  = 1'b0;
  endtask

  task automatic random_move_run();
    logic [2:0]  ax;
    logic [31:0] cnt;
    logic [15:0] hp;
    if (!drv_on || estop_held || $urandom_range(0, 9) == 0)
      send_cmd(OP_ENABLE, 3'($urandom), $urandom, 16'($urandom));
    ax  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    cnt = ($urandom_range(0, 4) == 0) ? $urandom : 32'(int'($urandom_range(0, 12)) - 6);
    hp  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(5, 12)) : 16'($urandom_range(0, 3));
    send_item(OP_MOVE, ax, cnt, hp, $urandom_range(0, 19) != 0, 5'($urandom), 5'($urandom));
    settle_run(150, 1'b0);
    if ($urandom_range(0, 2) == 0) send_cmd(OP_STATUS, ax, $urandom, 16'($urandom));
  endtask

  task automatic random_home_run();
    send_item(OP_HOME, 3'($urandom), $urandom, 16'($urandom), 1'($urandom),
              5'($urandom), 5'($urandom));
    settle_run(300, 1'b1);
    repeat ($urandom_range(0, 3)) send_cmd(OP_STATUS, 3'($urandom), $urandom, 16'($urandom));
  endtask

  // Any operation with any fields; moves that would start get a short half period
  task automatic random_noise(input int n);
    logic [2:0]  op;
    logic [2:0]  ax;
    logic [15:0] hp;
    repeat (n) begin
      op = 3'($urandom);
      ax = 3'($urandom);
      hp = 16'($urandom);
      if (op == OP_MOVE && mode == MODE_IDLE && ax < AXES && drv_on)
        hp = 16'($urandom_range(0, 3));
      send_item(op, ax, $urandom, hp, $urandom_range(0, 3) != 0, 5'($urandom), 5'($urandom));
      if (mode != MODE_IDLE) settle_run(100, mode == MODE_HOME);
    end
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    int runs;
    first = items_sent;
    runs  = 0;
    while (items_sent - first < 1600) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) random_move_run();
      else if (pick < 8) random_home_run();
      else random_noise($urandom_range(1, 8));
      runs++;
      if (runs % 10 == 0) write_home_period(16'($urandom_range(1, 3)));
    end
    // back to the longest homing period, limits all hit
    write_home_period(16'hFFFF);
    send_cmd(OP_HOME, 3'd0, 32'd0, 16'd0);
    repeat (5) send_tick(1'b1, 5'h00, 5'($urandom));
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    for (int i = 0; i < AXES; i++) pos_tab[i] = '0;
    drv_on     = 1'b0;
    estop_held = 1'b0;
    mode       = MODE_IDLE;
    cur_axis   = '0;
    steps_rem  = '0;
    dir_pos    = 1'b0;
    timer      = '0;
    pulse_on   = 1'b0;
    half_per   = '0;
    home_hp    = HOME_HP_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_moves();
    test_homing();
    test_backpressure();
    test_random_traffic();

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hw/rtl/msdc_pkg.sv
hw/rtl/msdc_ram.sv
hw/rtl/msdc_ctrl.sv
hw/rtl/msdc_pos.sv
hw/rtl/msdc_outq.sv
hw/rtl/multi_axis_step_dir_controller.sv
hw/rtl/msdc_checker.sv
test/tb_top.sv
